>>> src/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, constants and helpers of the IR pulse-distance decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    localparam int CODE_BITS_DEF = 32;
    localparam int KEY_W         = 32;
    localparam int TIME_W        = 16;
    localparam int REG_IDX_W     = 4;

    // Configuration register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_LEADER_MIN = 4'd0,
        REG_LEADER_MAX = 4'd1,
        REG_REPEAT_MIN = 4'd2,
        REG_REPEAT_MAX = 4'd3,
        REG_ONE_MIN    = 4'd4,
        REG_ONE_MAX    = 4'd5,
        REG_ZERO_MIN   = 4'd6,
        REG_ZERO_MAX   = 4'd7
    } irpd_reg_t;

    localparam logic [TIME_W-1:0] LEADER_MIN_RST = 16'd3980;
    localparam logic [TIME_W-1:0] LEADER_MAX_RST = 16'd4316;
    localparam logic [TIME_W-1:0] REPEAT_MIN_RST = 16'd3232;
    localparam logic [TIME_W-1:0] REPEAT_MAX_RST = 16'd3568;
    localparam logic [TIME_W-1:0] ONE_MIN_RST    = 16'd602;
    localparam logic [TIME_W-1:0] ONE_MAX_RST    = 16'd780;
    localparam logic [TIME_W-1:0] ZERO_MIN_RST   = 16'd256;
    localparam logic [TIME_W-1:0] ZERO_MAX_RST   = 16'd434;

    // Interval windows, all bounds exclusive.
    typedef struct packed {
        logic [TIME_W-1:0] leader_min;
        logic [TIME_W-1:0] leader_max;
        logic [TIME_W-1:0] repeat_min;
        logic [TIME_W-1:0] repeat_max;
        logic [TIME_W-1:0] one_min;
        logic [TIME_W-1:0] one_max;
        logic [TIME_W-1:0] zero_min;
        logic [TIME_W-1:0] zero_max;
    } irpd_win_t;

    // Result of the decode step for the item now in the input register.
    typedef struct packed {
        logic             emit;
        logic [KEY_W-1:0] key_code;
        logic             is_repeat;
    } irpd_res_t;

    // Frame state exported for checking.
    typedef struct packed {
        logic       armed;
        logic       in_data;
        logic       bits_zero;
        logic       bits_over;
    } irpd_stat_t;

    function automatic logic in_window(input logic [TIME_W-1:0] v,
                                       input logic [TIME_W-1:0] lo,
                                       input logic [TIME_W-1:0] hi);
        in_window = (v > lo) && (v < hi);
    endfunction

endpackage

>>> src/irpd_if.sv
// ----------------------------------------------------------------------------
// irpd_if
// Handshake channels of the decoder: edge times in, key codes out, config.
// ----------------------------------------------------------------------------
interface irpd_edge_if;
    import irpd_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] edge_time;

    modport source (output valid, output edge_time, input ready);
    modport sink (input valid, input edge_time, output ready);
endinterface

interface irpd_key_if;
    import irpd_pkg::*;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_code;
    logic             is_repeat;

    modport source (output valid, output key_code, output is_repeat, input ready);
    modport sink (input valid, input key_code, input is_repeat, output ready);
endinterface

interface irpd_cfg_if;
    import irpd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [TIME_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/ir_pulse_distance_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder: edges pass the input register, key items the
// result register. Throughput is one edge per cycle but for stalls on the
// key side. Reset clears frame state, loads the default timing windows at once.
// ----------------------------------------------------------------------------
//
// Each accepted item is one capture of the free-running 16-bit timer taken
// at an IR edge. The item lands in the input register, where the decode
// logic measures the wrapping interval to the previous edge, compares
// it against the leader, repeat, one and zero windows, and updates the frame
// state. A finished code (or a repeat frame, which re-sends the held code with
// is_repeat set) is written to the result register and offered on the key
// channel.
//
// The input register moves on whenever its item produces no result or the
// result register is free or being drained, so an edge can be accepted on
// every cycle while a key item still waits downstream. Configuration writes
// are taken at any time and are expected only while the decoder is idle.
module ir_pulse_distance_decoder #(
    parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    irpd_edge_if.sink   edges,
    irpd_key_if.source  keys,
    irpd_cfg_if.sink    cfg
);
    import irpd_pkg::*;

    irpd_win_t          win;
    irpd_res_t          res;
    irpd_stat_t         stat;

    logic               in_valid_reg, in_valid_next;
    logic [TIME_W-1:0]  in_time_reg;
    logic               out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]   out_code_reg;
    logic               out_rpt_reg;

    logic               in_fire;
    logic               advance;
    logic               out_load;

    irpd_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .win   (win)
    );

    irpd_core #(
        .CODE_BITS (CODE_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .now   (in_time_reg),
        .win   (win),
        .res   (res),
        .stat  (stat)
    );

    // The held item is decoded when its result, if any, has somewhere to go.
    assign advance  = in_valid_reg && (!res.emit || !out_valid_reg || keys.ready);
    assign out_load = advance && res.emit;

    assign edges.ready = !in_valid_reg || advance;
    assign in_fire     = edges.valid && edges.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (keys.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_time_reg <= edges.edge_time;
        end
        if (out_load)
        begin
            out_code_reg <= res.key_code;
            out_rpt_reg  <= res.is_repeat;
        end
    end

    assign keys.valid     = out_valid_reg;
    assign keys.key_code  = out_code_reg;
    assign keys.is_repeat = out_rpt_reg;

`ifndef ASSERT_OFF
    // Data mode is only ever entered from the armed state.
    a_data_armed: assert property (@(posedge clk) disable iff (!rst_n)
        stat.in_data |-> stat.armed)
        else $error("decoder in data mode while not armed");

    // The bit counter stays within one frame and never rests at zero.
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.bits_zero && !stat.bits_over)
        else $error("bit counter out of range");

    // A new key item appears only after a decode step produced it.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(keys.valid) |-> $past(advance && res.emit))
        else $error("key item raised without a decode step");

    // Every emitted result ends the frame and disarms the decoder.
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> !stat.armed && !stat.in_data)
        else $error("decoder still armed after emitting a key item");
`endif

endmodule

>>> src/irpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// irpd_cfg_regs
// Window threshold registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module irpd_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    irpd_cfg_if.sink           cfg,
    output irpd_pkg::irpd_win_t win
);
    import irpd_pkg::*;

    irpd_win_t win_reg;
    irpd_win_t win_next;

    assign cfg.ready = 1'b1;
    assign win       = win_reg;

    always_comb
    begin
        win_next = win_reg;
        if (cfg.valid)
        begin
            unique case (irpd_reg_t'(cfg.index))
                REG_LEADER_MIN: win_next.leader_min = cfg.data;
                REG_LEADER_MAX: win_next.leader_max = cfg.data;
                REG_REPEAT_MIN: win_next.repeat_min = cfg.data;
                REG_REPEAT_MAX: win_next.repeat_max = cfg.data;
                REG_ONE_MIN:    win_next.one_min    = cfg.data;
                REG_ONE_MAX:    win_next.one_max    = cfg.data;
                REG_ZERO_MIN:   win_next.zero_min   = cfg.data;
                REG_ZERO_MAX:   win_next.zero_max   = cfg.data;
                default:        win_next = win_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.leader_min <= LEADER_MIN_RST;
            win_reg.leader_max <= LEADER_MAX_RST;
            win_reg.repeat_min <= REPEAT_MIN_RST;
            win_reg.repeat_max <= REPEAT_MAX_RST;
            win_reg.one_min    <= ONE_MIN_RST;
            win_reg.one_max    <= ONE_MAX_RST;
            win_reg.zero_min   <= ZERO_MIN_RST;
            win_reg.zero_max   <= ZERO_MAX_RST;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

endmodule

>>> src/irpd_core.sv
// ----------------------------------------------------------------------------
// irpd_core
// Frame state and the single-pass decode of one captured edge time.
// ----------------------------------------------------------------------------
module irpd_core #(
    parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [irpd_pkg::TIME_W-1:0] now,
    input  irpd_pkg::irpd_win_t         win,
    output irpd_pkg::irpd_res_t         res,
    output irpd_pkg::irpd_stat_t        stat
);
    import irpd_pkg::*;

    localparam int CNT_W = $clog2(CODE_BITS + 1);
    localparam int IDX_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
    localparam logic [CNT_W-1:0] BITS_FULL = CNT_W'(CODE_BITS);

    logic                 armed_reg, armed_next;
    logic                 in_data_reg, in_data_next;
    logic [TIME_W-1:0]    last_edge_reg, last_edge_next;
    logic [CNT_W-1:0]     bits_left_reg, bits_left_next;
    logic [CODE_BITS-1:0] code_reg, code_next;

    logic [TIME_W-1:0]    width;
    logic [CNT_W-1:0]     bits_dec;
    logic [IDX_W-1:0]     bit_idx;

    assign width    = now - last_edge_reg;
    assign bits_dec = bits_left_reg - CNT_W'(1);
    assign bit_idx  = bits_dec[IDX_W-1:0];

    always_comb
    begin
        armed_next     = armed_reg;
        in_data_next   = in_data_reg;
        last_edge_next = now;
        bits_left_next = bits_left_reg;
        code_next      = code_reg;
        res.emit       = 1'b0;
        res.key_code   = KEY_W'(code_reg);
        res.is_repeat  = 1'b0;

        if (!armed_reg)
        begin
            armed_next     = 1'b1;
            bits_left_next = BITS_FULL;
        end
        else if (!in_data_reg)
        begin
            priority if (in_window(width, win.leader_min, win.leader_max))
            begin
                in_data_next = 1'b1;
            end
            else if (in_window(width, win.repeat_min, win.repeat_max))
            begin
                res.emit      = 1'b1;
                res.is_repeat = 1'b1;
                armed_next    = 1'b0;
            end
            else
            begin
                armed_next = 1'b0;
            end
        end
        else
        begin
            priority if (in_window(width, win.one_min, win.one_max))
            begin
                if (bits_left_reg != '0)
                begin
                    bits_left_next     = bits_dec;
                    code_next[bit_idx] = 1'b1;
                end
            end
            else if (in_window(width, win.zero_min, win.zero_max))
            begin
                if (bits_left_reg != '0)
                begin
                    bits_left_next     = bits_dec;
                    code_next[bit_idx] = 1'b0;
                end
            end
            else
            begin
                armed_next   = 1'b0;
                in_data_next = 1'b0;
            end

            // Last bit taken: the full code goes out and the frame ends.
            if (bits_left_next == '0)
            begin
                res.emit       = 1'b1;
                res.key_code   = KEY_W'(code_next);
                bits_left_next = BITS_FULL;
                armed_next     = 1'b0;
                in_data_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            in_data_reg   <= 1'b0;
            last_edge_reg <= '0;
            bits_left_reg <= BITS_FULL;
            code_reg      <= '0;
        end
        else if (step)
        begin
            armed_reg     <= armed_next;
            in_data_reg   <= in_data_next;
            last_edge_reg <= last_edge_next;
            bits_left_reg <= bits_left_next;
            code_reg      <= code_next;
        end
    end

    assign stat.armed     = armed_reg;
    assign stat.in_data   = in_data_reg;
    assign stat.bits_zero = (bits_left_reg == '0);
    assign stat.bits_over = (bits_left_reg > BITS_FULL);

endmodule

>>> test/ir_decode_checker.sv
// ----------------------------------------------------------------------------
// ir_decode_checker
// Watches the edge, key and configuration channels of the IR pulse-distance
// decoder, predicts every key item from the accepted edges and compares the
// key items the decoder hands out against that prediction, oldest first.
// ----------------------------------------------------------------------------
module ir_decode_checker #(
    parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    irpd_edge_if edges,
    irpd_key_if  keys,
    irpd_cfg_if  cfg,
    output int   pending,
    output int   mismatches,
    output int   edges_seen,
    output int   codes_seen,
    output int   repeats_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import irpd_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0] key_code;
        logic             is_repeat;
    } key_item_t;

    // Shadow of the decoder: timing windows and frame state.
    irpd_win_t         win;
    logic              armed;
    logic              in_data;
    logic [TIME_W-1:0] prev_edge;
    logic [5:0]        bits_left;
    logic [KEY_W-1:0]  code_reg;
    key_item_t         expected_keys[$];
    int                keys_taken;

    function automatic logic between(input logic [TIME_W-1:0] v,
                                     input logic [TIME_W-1:0] lo,
                                     input logic [TIME_W-1:0] hi);
        return (v > lo) && (v < hi);
    endfunction

    task automatic report(input string what);
        $display("[%0t] decode check: %s", $time, what);
        mismatches++;
    endtask

    // Advance the frame state by one edge and queue any key item it causes.
    task automatic decode_edge(input logic [TIME_W-1:0] now_t);
        logic [TIME_W-1:0] span;
        if (!armed)
        begin
            prev_edge = now_t;
            armed     = 1'b1;
            bits_left = 6'(CODE_BITS);
            return;
        end
        span      = now_t - prev_edge;
        prev_edge = now_t;
        if (!in_data)
        begin
            if (between(span, win.leader_min, win.leader_max))
            begin
                in_data = 1'b1;
            end
            else if (between(span, win.repeat_min, win.repeat_max))
            begin
                expected_keys.push_back('{code_reg, 1'b1});
                armed = 1'b0;
            end
            else
            begin
                armed = 1'b0;
            end
            return;
        end
        if (between(span, win.one_min, win.one_max))
        begin
            if (bits_left != 0)
            begin
                bits_left--;
                code_reg[bits_left[4:0]] = 1'b1;
            end
        end
        else if (between(span, win.zero_min, win.zero_max))
        begin
            if (bits_left != 0)
            begin
                bits_left--;
                code_reg[bits_left[4:0]] = 1'b0;
            end
        end
        else
        begin
            armed   = 1'b0;
            in_data = 1'b0;
        end
        if (bits_left == 0)
        begin
            expected_keys.push_back('{code_reg, 1'b0});
            bits_left = 6'(CODE_BITS);
            armed     = 1'b0;
            in_data   = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        key_item_t want;
        if (!rst_n)
        begin
            win = '{LEADER_MIN_RST, LEADER_MAX_RST, REPEAT_MIN_RST, REPEAT_MAX_RST,
                    ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST};
            armed        = 1'b0;
            in_data      = 1'b0;
            prev_edge    = '0;
            bits_left    = 6'(CODE_BITS);
            code_reg     = '0;
            expected_keys.delete();
            keys_taken   = 0;
            mismatches   = 0;
            edges_seen   = 0;
            codes_seen   = 0;
            repeats_seen = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (irpd_reg_t'(cfg.index))
                    REG_LEADER_MIN: win.leader_min = cfg.data;
                    REG_LEADER_MAX: win.leader_max = cfg.data;
                    REG_REPEAT_MIN: win.repeat_min = cfg.data;
                    REG_REPEAT_MAX: win.repeat_max = cfg.data;
                    REG_ONE_MIN:    win.one_min    = cfg.data;
                    REG_ONE_MAX:    win.one_max    = cfg.data;
                    REG_ZERO_MIN:   win.zero_min   = cfg.data;
                    REG_ZERO_MAX:   win.zero_max   = cfg.data;
                    default: ;
                endcase
            end
            if (edges.valid && edges.ready)
            begin
                edges_seen++;
                decode_edge(edges.edge_time);
            end
            if (keys.valid && keys.ready)
            begin
                keys_taken++;
                if (expected_keys.size() == 0)
                begin
                    report($sformatf("key item %0d came with none predicted: 0x%08h repeat %0b",
                                     keys_taken, keys.key_code, keys.is_repeat));
                end
                else
                begin
                    want = expected_keys.pop_front();
                    if (keys.key_code !== want.key_code)
                        report($sformatf("key item %0d: key_code 0x%08h, predicted 0x%08h",
                                         keys_taken, keys.key_code, want.key_code));
                    if (keys.is_repeat !== want.is_repeat)
                        report($sformatf("key item %0d: is_repeat %0b, predicted %0b",
                                         keys_taken, keys.is_repeat, want.is_repeat));
                    if (want.is_repeat)
                        repeats_seen++;
                    else
                        codes_seen++;
                end
            end
        end
        pending = expected_keys.size();
    end

endmodule

>>> test/ir_pulse_distance_decoder_tb.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_tb
// Drives IR edge captures and window settings into the pulse-distance decoder
// and leaves prediction and comparison of the key items to ir_decode_checker.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irpd_pkg::*;

    localparam int FRAME_BITS  = CODE_BITS_DEF;
    // Far above the slowest correct run.
    localparam int CYCLE_LIMIT = 300000;

    logic clk;
    logic rst_n;

    irpd_edge_if edge_ch ();
    irpd_key_if  key_ch ();
    irpd_cfg_if  cfg_ch ();

    int pending;
    int mismatches;
    int edges_seen;
    int codes_seen;
    int repeats_seen;

    // Stimulus state: timer value of the last edge sent, the windows as last
    // written, and whether the decoder is known to sit disarmed.
    logic [TIME_W-1:0] now_t;
    irpd_win_t         ws;
    bit                synced;
    int                items_fed;
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                cycle_count;

    ir_pulse_distance_decoder #(.CODE_BITS(FRAME_BITS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .edges (edge_ch),
        .keys  (key_ch),
        .cfg   (cfg_ch)
    );

    ir_decode_checker #(.CODE_BITS(FRAME_BITS)) chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .edges        (edge_ch),
        .keys         (key_ch),
        .cfg          (cfg_ch),
        .pending      (pending),
        .mismatches   (mismatches),
        .edges_seen   (edges_seen),
        .codes_seen   (codes_seen),
        .repeats_seen (repeats_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The key side stalls at random, cycle by cycle, at the current rate.
    initial
    begin
        key_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            key_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: a run that never drains its predicted key items ends here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d key items outstanding",
                 cycle_count, pending);
        $display("Mismatches found");
        $finish;
    end

    // A value strictly inside the window (lo, hi), often right at its edges.
    // An empty or one-value-short window gives a random value instead.
    function automatic logic [TIME_W-1:0] pick_in(input logic [TIME_W-1:0] lo,
                                                  input logic [TIME_W-1:0] hi);
        int unsigned r;
        if (hi <= lo || hi - lo < 2)
            return TIME_W'($urandom_range(65535));
        r = $urandom_range(3);
        if (r == 0)
            return lo + 16'd1;
        if (r == 1)
            return hi - 16'd1;
        return lo + TIME_W'($urandom_range(hi - lo - 1, 1));
    endfunction

    function automatic logic hits(input logic [TIME_W-1:0] v,
                                  input logic [TIME_W-1:0] lo,
                                  input logic [TIME_W-1:0] hi);
        return (v > lo) && (v < hi);
    endfunction

    // Any interval at all: the extremes, random values and each window.
    function automatic logic [TIME_W-1:0] noise_span();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return pick_in(ws.leader_min, ws.leader_max);
            3:       return pick_in(ws.repeat_min, ws.repeat_max);
            4:       return pick_in(ws.one_min, ws.one_max);
            5:       return pick_in(ws.zero_min, ws.zero_max);
            6:       return TIME_W'($urandom_range(1023));
            default: return TIME_W'($urandom_range(65535));
        endcase
    endfunction

    // One edge item at absolute timer value t. The sender idles per cycle at
    // tx_idle_pct before offering it, then holds it until the decoder takes it.
    task automatic send_edge(input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            edge_ch.valid <= 1'b0;
            @(posedge clk);
        end
        edge_ch.valid     <= 1'b1;
        edge_ch.edge_time <= t;
        do @(posedge clk); while (!edge_ch.ready);
        now_t = t;
        items_fed++;
    endtask

    // The timer wraps, so an edge span ticks after the last one may land
    // below it; the decoder has to see the wrapped difference.
    task automatic send_span(input logic [TIME_W-1:0] span);
        send_edge(now_t + span);
    endtask

    // Offers one register write. The caller lowers valid after its last write,
    // so back-to-back writes keep valid high without a glitch.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Stop feeding edges and wait until every predicted key item has come out.
    // An edge that causes no key item may still be in flight at that point, so
    // the task waits on until it has left the input register.
    task automatic settle();
        edge_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Rewrites all eight window bounds while the decoder is idle. A write to an
    // unmapped index goes first; the decoder must ignore it.
    task automatic load_windows(input irpd_win_t w);
        settle();
        write_reg(REG_IDX_W'($urandom_range(15, 8)), TIME_W'($urandom_range(65535)));
        write_reg(REG_LEADER_MIN, w.leader_min);
        write_reg(REG_LEADER_MAX, w.leader_max);
        write_reg(REG_REPEAT_MIN, w.repeat_min);
        write_reg(REG_REPEAT_MAX, w.repeat_max);
        write_reg(REG_ONE_MIN, w.one_min);
        write_reg(REG_ONE_MAX, w.one_max);
        write_reg(REG_ZERO_MIN, w.zero_min);
        write_reg(REG_ZERO_MAX, w.zero_max);
        cfg_ch.valid <= 1'b0;
        ws = w;
    endtask

    // A frame from a disarmed decoder: arming edge at a random timer value,
    // leader, then the code MSB first. When cut is below FRAME_BITS the frame
    // breaks after that many bits with an interval that fits neither bit window,
    // which leaves a partly overwritten code behind for a later repeat frame.
    task automatic send_frame(input logic [KEY_W-1:0] code, input int cut);
        logic [TIME_W-1:0] bad;
        send_edge(TIME_W'($urandom_range(65535)));
        send_span(pick_in(ws.leader_min, ws.leader_max));
        for (int i = 0; i < cut; i++)
            send_span(code[FRAME_BITS-1-i] ? pick_in(ws.one_min, ws.one_max)
                                           : pick_in(ws.zero_min, ws.zero_max));
        if (cut < FRAME_BITS)
        begin
            // Half the time the exact window bounds, which a strict compare rejects.
            case ($urandom_range(7))
                0:       bad = '0;
                1:       bad = '1;
                2:       bad = ws.one_min;
                3:       bad = ws.one_max;
                4:       bad = ws.zero_min;
                5:       bad = ws.zero_max;
                6:       bad = pick_in(ws.leader_min, ws.leader_max);
                default: bad = TIME_W'($urandom_range(65535));
            endcase
            if (hits(bad, ws.one_min, ws.one_max) || hits(bad, ws.zero_min, ws.zero_max))
                bad = '0;
            send_span(bad);
        end
    endtask

    // Well-formed traffic with random content under sane windows: full frames,
    // repeat frames, broken frames, rejected first intervals and bursts of noise.
    task automatic run_frames(input int n);
        int                stop_at;
        int                pick;
        logic [KEY_W-1:0]  code;
        logic [TIME_W-1:0] bad;
        stop_at = items_fed + n;
        while (items_fed < stop_at)
        begin
            if (!synced)
            begin
                // Leader, zero span, leader, zero span takes the decoder from
                // any state to disarmed while the leader fits no bit window.
                repeat (2)
                begin
                    send_span(pick_in(ws.leader_min, ws.leader_max));
                    send_span('0);
                end
                synced = 1'b1;
            end
            case ($urandom_range(9))
                0:       code = '0;
                1:       code = '1;
                default: code = $urandom;
            endcase
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                send_frame(code, FRAME_BITS);
            end
            else if (pick < 65)
            begin
                send_edge(TIME_W'($urandom_range(65535)));
                send_span(pick_in(ws.repeat_min, ws.repeat_max));
            end
            else if (pick < 80)
            begin
                send_frame(code, $urandom_range(FRAME_BITS - 1));
            end
            else if (pick < 87)
            begin
                // Armed, then an interval that is neither leader nor repeat.
                case ($urandom_range(6))
                    0:       bad = '0;
                    1:       bad = '1;
                    2:       bad = ws.leader_min;
                    3:       bad = ws.leader_max;
                    4:       bad = ws.repeat_min;
                    5:       bad = ws.repeat_max;
                    default: bad = TIME_W'($urandom_range(65535));
                endcase
                if (hits(bad, ws.leader_min, ws.leader_max)
                    || hits(bad, ws.repeat_min, ws.repeat_max))
                    bad = '0;
                send_edge(TIME_W'($urandom_range(65535)));
                send_span(bad);
            end
            else
            begin
                repeat ($urandom_range(6, 1)) send_span(noise_span());
                synced = 1'b0;
            end
        end
    endtask

    // Pure noise, used under the extreme window settings.
    task automatic run_noise(input int n);
        repeat (n) send_span(noise_span());
        synced = 1'b0;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        edge_ch.valid     = 1'b0;
        edge_ch.edge_time = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        now_t             = '0;
        synced            = 1'b1;
        items_fed         = 0;
        tx_idle_pct       = 25;
        rx_idle_pct       = 76;
        ws = '{LEADER_MIN_RST, LEADER_MAX_RST, REPEAT_MIN_RST, REPEAT_MAX_RST,
               ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset windows. A repeat right after reset
        // sends the cleared code; the first span wraps past zero.
        send_edge(16'hFFFF);
        send_span(16'd3400);
        // A leader exactly on its lower bound is rejected.
        send_edge(16'h0000);
        send_span(LEADER_MIN_RST);
        // Leader just under its upper bound, then a bit exactly on one_max.
        send_edge(16'h5555);
        send_span(LEADER_MAX_RST - 16'd1);
        send_span(ONE_MAX_RST);
        // Four bits at the inner edges of both bit windows, then a zero span.
        send_edge(16'hAAAA);
        send_span(LEADER_MIN_RST + 16'd1);
        send_span(ONE_MIN_RST + 16'd1);
        send_span(ZERO_MAX_RST - 16'd1);
        send_span(ZERO_MIN_RST + 16'd1);
        send_span(ONE_MAX_RST - 16'd1);
        send_span(16'd0);
        // Repeats now send the partly overwritten code.
        send_span(16'd1234);
        send_span(REPEAT_MIN_RST + 16'd1);
        send_span(16'd7);
        send_span(REPEAT_MAX_RST - 16'd1);
        // Repeat bounds themselves and the widest span are all rejected.
        send_span(16'd9);
        send_span(REPEAT_MIN_RST);
        send_span(16'd11);
        send_span(16'hFFFF);
        send_span(16'd13);
        send_span(REPEAT_MAX_RST);

        // Sender idles a quarter of the time, receiver three quarters.
        run_frames(400);
        // Extreme: leader and bit windows empty, spans but 0 and 0xFFFF repeat.
        load_windows('{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                       16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000});
        run_noise(70);

        // The other way round.
        tx_idle_pct = 76;
        rx_idle_pct = 25;
        // Narrow windows, some admitting just one or two values.
        load_windows('{16'd5000, 16'd5002, 16'd6000, 16'd6100,
                       16'd1999, 16'd2001, 16'd99, 16'd102});
        run_frames(400);
        // Extreme: the leader window takes all but 0 and 0xFFFF, shadowing the
        // repeat window; the one window overlaps and wins over the zero window.
        load_windows('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                       16'h0000, 16'd32768, 16'd16000, 16'hFFFF});
        run_noise(100);

        // Neither side idles.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_windows('{16'd3000, 16'd4500, 16'd2000, 16'd2999,
                       16'd500, 16'd1000, 16'd100, 16'd499});
        run_frames(450);

        settle();

        $display("Fed %0d edge items through five window settings and three stall patterns,",
                 edges_seen);
        $display("getting back %0d full codes and %0d repeat frames.", codes_seen, repeats_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
src/irpd_pkg.sv
src/irpd_if.sv
src/irpd_cfg_regs.sv
src/irpd_core.sv
src/ir_pulse_distance_decoder.sv
test/ir_decode_checker.sv
test/ir_pulse_distance_decoder_tb.sv
